// File: rtl/slp_pkg.sv
// shared constants, register codes and configuration type of the shelf layout placer
package slp_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int GROUP_BITS_DEF = 16;
    localparam int TRIM_BITS      = 14;
    localparam int SHEET_BITS     = 16;
    localparam int PAD_BITS       = 8;
    localparam int EXTRUDE_GROW   = 2;
    localparam int MID_DEPTH      = 4;
    localparam int OUT_DEPTH      = 2;
    localparam int ADDR_BITS      = 5;
    localparam int DATA_BITS      = 32;
    localparam int REG_IDX_BITS   = 3;

    typedef enum logic [REG_IDX_BITS-1:0] {
        REG_COLUMNS_MODE   = 3'd0,
        REG_BORDER_PADDING = 3'd1,
        REG_SHAPE_PADDING  = 3'd2,
        REG_INNER_PADDING  = 3'd3,
        REG_EXTRUDE        = 3'd4,
        REG_SHEET_WIDTH    = 3'd5,
        REG_SHEET_HEIGHT   = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic                  columns_mode;
        logic [PAD_BITS-1:0]   border_padding;
        logic [PAD_BITS-1:0]   shape_padding;
        logic [PAD_BITS-1:0]   inner_padding;
        logic                  extrude;
        logic [SHEET_BITS-1:0] sheet_width;
        logic [SHEET_BITS-1:0] sheet_height;
    } t_cfg;

endpackage

// File: rtl/slp_queue.sv
// small first-in first-out queue of words held in flip-flops
module slp_queue import slp_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = MID_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd,
    output logic [WIDTH-1:0] o_rd_data,
    output logic             o_full,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_wr) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_rd) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({i_wr, i_rd})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    assign o_rd_data = r_mem[r_rd_ptr];
    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_empty   = (r_count == '0);

endmodule

// File: rtl/slp_front.sv
// front end: accepts a rectangle, pads its size and flags empty ones
module slp_front import slp_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int GROUP_BITS = GROUP_BITS_DEF
) (
    input  t_cfg                               i_cfg,
    input  logic                               i_push,
    input  logic                               i_full,
    input  logic                               i_restart,
    input  logic [TRIM_BITS-1:0]               i_trim_width,
    input  logic [TRIM_BITS-1:0]               i_trim_height,
    input  logic [GROUP_BITS-1:0]              i_group_id,
    output logic                               o_wr,
    output logic [2*COORD_BITS+GROUP_BITS+1:0] o_entry
);

    localparam int C    = COORD_BITS;
    localparam int EXW  = PAD_BITS + 2;
    localparam int SUMW = ((C > TRIM_BITS + 1) ? C : TRIM_BITS + 1) + 1;

    logic [EXW-1:0]  extra;
    logic [SUMW-1:0] sum_w;
    logic [SUMW-1:0] sum_h;
    logic [C-1:0]    pad_w;
    logic [C-1:0]    pad_h;
    logic            is_empty;

    always_comb begin
        extra = EXW'({i_cfg.inner_padding, 1'b0})
              + (i_cfg.extrude ? EXW'(EXTRUDE_GROW) : '0);
        sum_w = SUMW'(i_trim_width) + SUMW'(extra);
        sum_h = SUMW'(i_trim_height) + SUMW'(extra);
        pad_w = (|sum_w[SUMW-1:C]) ? {C{1'b1}} : sum_w[C-1:0];
        pad_h = (|sum_h[SUMW-1:C]) ? {C{1'b1}} : sum_h[C-1:0];
        is_empty = (i_trim_width == '0) || (i_trim_height == '0);
    end

    assign o_wr    = i_push && !i_full;
    assign o_entry = {i_restart, is_empty, pad_w, pad_h, i_group_id};

endmodule

// File: rtl/slp_back.sv
// back end: shelf cursor update, then sheet extent and totals
module slp_back import slp_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int GROUP_BITS = GROUP_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  t_cfg                               i_cfg,
    input  logic                               i_valid,
    input  logic [2*COORD_BITS+GROUP_BITS+1:0] i_entry,
    output logic                               o_take,
    input  logic                               i_out_full,
    output logic                               o_wr,
    output logic [6*COORD_BITS-1:0]            o_result,
    output logic                               o_busy
);

    localparam int C  = COORD_BITS;
    localparam int G  = GROUP_BITS;
    localparam int AW = C + 2;
    localparam int CW = ((C > SHEET_BITS) ? C : SHEET_BITS) + 2;

    function automatic logic [C-1:0] sat_a(input logic [AW-1:0] v);
        return (|v[AW-1:C]) ? {C{1'b1}} : v[C-1:0];
    endfunction

    function automatic logic [C-1:0] sat_c(input logic [CW-1:0] v);
        return (|v[CW-1:C]) ? {C{1'b1}} : v[C-1:0];
    endfunction

    function automatic logic [C-1:0] umax(input logic [C-1:0] a, input logic [C-1:0] b);
        return (a > b) ? a : b;
    endfunction

    // queue head
    logic         e_restart;
    logic         e_empty;
    logic [C-1:0] e_pw;
    logic [C-1:0] e_ph;
    logic [G-1:0] e_grp;

    assign e_restart = i_entry[2*C+G+1];
    assign e_empty   = i_entry[2*C+G];
    assign e_pw      = i_entry[2*C+G-1 -: C];
    assign e_ph      = i_entry[C+G-1 -: C];
    assign e_grp     = i_entry[G-1:0];

    // layout state
    logic [C-1:0] r_cx, r_cy, r_sw, r_sh;
    logic [G-1:0] r_prev;
    logic         r_has;
    logic [C-1:0] n_cx, n_cy, n_sw, n_sh;
    logic [G-1:0] n_prev;
    logic         n_has;

    // second stage
    logic         r_b_valid, r_b_restart, r_b_empty, r_b_has;
    logic [C-1:0] r_b_px, r_b_py, r_b_pw, r_b_ph;
    logic [C-1:0] r_mr, r_mb;

    logic         stall;
    logic [C-1:0] bpad;
    logic [C-1:0] a_cx, a_cy, a_sw, a_sh;
    logic [G-1:0] a_prev;
    logic         a_has;
    logic         wrap_col, wrap_row;
    logic [C-1:0] cx_wrap, cy_wrap;
    logic [C-1:0] px, py, sw0, sh0;
    logic [C-1:0] out_px, out_py, out_pw, out_ph;

    logic [C-1:0]  m_r, m_b, ext_r, ext_b;
    logic          sheet_full;
    logic [CW-1:0] t_w, t_h;
    logic [C-1:0]  tot_w, tot_h;

    assign stall  = r_b_valid && i_out_full;
    assign o_take = i_valid && !stall;
    assign o_wr   = r_b_valid && !i_out_full;
    assign o_busy = r_b_valid;
    assign bpad   = C'(i_cfg.border_padding);

    always_comb begin
        a_cx   = r_cx;
        a_cy   = r_cy;
        a_sw   = r_sw;
        a_sh   = r_sh;
        a_prev = r_prev;
        a_has  = r_has;
        if (e_restart) begin
            a_cx   = bpad;
            a_cy   = bpad;
            a_sw   = '0;
            a_sh   = '0;
            a_prev = '0;
            a_has  = 1'b0;
        end

        wrap_col = (i_cfg.sheet_height == '0) ? (e_grp != a_prev)
                 : ((CW'(a_cy) + CW'(e_ph) + CW'(i_cfg.border_padding))
                    > CW'(i_cfg.sheet_height));
        wrap_row = (i_cfg.sheet_width == '0) ? (e_grp != a_prev)
                 : ((CW'(a_cx) + CW'(e_pw) + CW'(i_cfg.border_padding))
                    > CW'(i_cfg.sheet_width));
        cx_wrap = sat_a(AW'(a_cx) + AW'(a_sw) + AW'(i_cfg.shape_padding));
        cy_wrap = sat_a(AW'(a_cy) + AW'(a_sh) + AW'(i_cfg.shape_padding));

        // placement corner and shelf extent before this rectangle
        if (!a_has) begin
            px  = bpad;
            py  = bpad;
            sw0 = '0;
            sh0 = '0;
        end else if (i_cfg.columns_mode && wrap_col) begin
            px  = cx_wrap;
            py  = bpad;
            sw0 = e_pw;
            sh0 = e_ph;
        end else if (!i_cfg.columns_mode && wrap_row) begin
            px  = bpad;
            py  = cy_wrap;
            sw0 = e_pw;
            sh0 = e_ph;
        end else begin
            px  = a_cx;
            py  = a_cy;
            sw0 = a_sw;
            sh0 = a_sh;
        end

        n_cx   = a_cx;
        n_cy   = a_cy;
        n_sw   = a_sw;
        n_sh   = a_sh;
        n_prev = a_prev;
        n_has  = a_has;
        out_px = '0;
        out_py = '0;
        out_pw = '0;
        out_ph = '0;
        if (!e_empty) begin
            if (i_cfg.columns_mode) begin
                n_cx = px;
                n_cy = sat_a(AW'(py) + AW'(e_ph) + AW'(i_cfg.shape_padding));
            end else begin
                n_cx = sat_a(AW'(px) + AW'(e_pw) + AW'(i_cfg.shape_padding));
                n_cy = py;
            end
            n_sw   = umax(sw0, e_pw);
            n_sh   = umax(sh0, e_ph);
            n_prev = e_grp;
            n_has  = 1'b1;
            out_px = px;
            out_py = py;
            out_pw = e_pw;
            out_ph = e_ph;
        end
    end

    always_comb begin
        m_r   = r_b_restart ? '0 : r_mr;
        m_b   = r_b_restart ? '0 : r_mb;
        ext_r = sat_a(AW'(r_b_px) + AW'(r_b_pw)
              + ((i_cfg.sheet_width != '0) ? AW'(i_cfg.border_padding) : '0));
        ext_b = sat_a(AW'(r_b_py) + AW'(r_b_ph)
              + ((i_cfg.sheet_height != '0) ? AW'(i_cfg.border_padding) : '0));
        if (!r_b_empty) begin
            m_r = umax(m_r, ext_r);
            m_b = umax(m_b, ext_b);
        end

        sheet_full = (i_cfg.sheet_width != '0) && (i_cfg.sheet_height != '0);
        if (sheet_full) begin
            t_w = (CW'(i_cfg.sheet_width) > CW'(m_r)) ? CW'(i_cfg.sheet_width) : CW'(m_r);
            t_h = (CW'(i_cfg.sheet_height) > CW'(m_b)) ? CW'(i_cfg.sheet_height) : CW'(m_b);
        end else begin
            t_w = r_b_has ? CW'(m_r) : CW'(i_cfg.sheet_width);
            t_h = r_b_has ? CW'(m_b) : CW'(i_cfg.sheet_height);
        end
        // a free dimension still carries the border
        if (i_cfg.sheet_width == '0) begin
            t_w = t_w + CW'(i_cfg.border_padding);
        end
        if (i_cfg.sheet_height == '0) begin
            t_h = t_h + CW'(i_cfg.border_padding);
        end
        tot_w = sat_c(t_w);
        tot_h = sat_c(t_h);
    end

    assign o_result = {r_b_px, r_b_py, r_b_pw, r_b_ph, tot_w, tot_h};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_has     <= 1'b0;
            r_b_valid <= 1'b0;
            r_mr      <= '0;
            r_mb      <= '0;
        end else begin
            if (o_take) begin
                r_cx        <= n_cx;
                r_cy        <= n_cy;
                r_sw        <= n_sw;
                r_sh        <= n_sh;
                r_prev      <= n_prev;
                r_has       <= n_has;
                r_b_restart <= e_restart;
                r_b_empty   <= e_empty;
                r_b_has     <= n_has;
                r_b_px      <= out_px;
                r_b_py      <= out_py;
                r_b_pw      <= out_pw;
                r_b_ph      <= out_ph;
            end
            if (!stall) begin
                r_b_valid <= o_take;
            end
            if (o_wr) begin
                r_mr <= m_r;
                r_mb <= m_b;
            end
        end
    end

endmodule

// File: rtl/shelf_layout_placer_core.sv
// A pushed word passes the middle queue, the back-end register stage and the result queue.
// Throughput: one rectangle per cycle while the result queue has room, set by the cursor
// update in the back end. A four-word middle queue and a two-word result queue absorb stalls.
// Reset (synchronous, active low) clears the configuration and extent registers, empties
// both queues and drops any layout in progress; cursor registers are ignored until the
// first placement, so no clearing pass is needed.
module shelf_layout_placer_core import slp_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int GROUP_BITS = GROUP_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_BITS-1:0]  paddr,
    input  logic [DATA_BITS-1:0]  pwdata,
    output logic [DATA_BITS-1:0]  prdata,
    output logic                  pready,
    input  logic                  push,
    output logic                  full,
    input  logic                  i_restart,
    input  logic [TRIM_BITS-1:0]  i_trim_width,
    input  logic [TRIM_BITS-1:0]  i_trim_height,
    input  logic [GROUP_BITS-1:0] i_group_id,
    output logic                  empty,
    input  logic                  pop,
    output logic [COORD_BITS-1:0] o_pos_x,
    output logic [COORD_BITS-1:0] o_pos_y,
    output logic [COORD_BITS-1:0] o_placed_width,
    output logic [COORD_BITS-1:0] o_placed_height,
    output logic [COORD_BITS-1:0] o_total_width,
    output logic [COORD_BITS-1:0] o_total_height
);

    localparam int C   = COORD_BITS;
    localparam int EW  = 2 * COORD_BITS + GROUP_BITS + 2;
    localparam int RW  = 6 * COORD_BITS;

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx reg_idx;
    logic     cfg_wr;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = t_reg_idx'(paddr[ADDR_BITS-1:2]);

    always_comb begin
        n_cfg = r_cfg;
        if (cfg_wr) begin
            unique case (reg_idx)
                REG_COLUMNS_MODE:   n_cfg.columns_mode   = pwdata[0];
                REG_BORDER_PADDING: n_cfg.border_padding = pwdata[PAD_BITS-1:0];
                REG_SHAPE_PADDING:  n_cfg.shape_padding  = pwdata[PAD_BITS-1:0];
                REG_INNER_PADDING:  n_cfg.inner_padding  = pwdata[PAD_BITS-1:0];
                REG_EXTRUDE:        n_cfg.extrude        = pwdata[0];
                REG_SHEET_WIDTH:    n_cfg.sheet_width    = pwdata[SHEET_BITS-1:0];
                REG_SHEET_HEIGHT:   n_cfg.sheet_height   = pwdata[SHEET_BITS-1:0];
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_COLUMNS_MODE:   prdata = DATA_BITS'(r_cfg.columns_mode);
            REG_BORDER_PADDING: prdata = DATA_BITS'(r_cfg.border_padding);
            REG_SHAPE_PADDING:  prdata = DATA_BITS'(r_cfg.shape_padding);
            REG_INNER_PADDING:  prdata = DATA_BITS'(r_cfg.inner_padding);
            REG_EXTRUDE:        prdata = DATA_BITS'(r_cfg.extrude);
            REG_SHEET_WIDTH:    prdata = DATA_BITS'(r_cfg.sheet_width);
            REG_SHEET_HEIGHT:   prdata = DATA_BITS'(r_cfg.sheet_height);
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    logic          front_wr;
    logic [EW-1:0] front_entry;
    logic [EW-1:0] mid_head;
    logic          mid_full;
    logic          mid_empty;
    logic          back_take;
    logic          back_wr;
    logic          back_busy;
    logic [RW-1:0] back_result;
    logic [RW-1:0] out_head;
    logic          out_full;
    logic          out_pop;

    assign full    = mid_full;
    assign out_pop = pop && !empty;

    slp_front #(
        .COORD_BITS (COORD_BITS),
        .GROUP_BITS (GROUP_BITS)
    ) u_front (
        .i_cfg         (r_cfg),
        .i_push        (push),
        .i_full        (mid_full),
        .i_restart     (i_restart),
        .i_trim_width  (i_trim_width),
        .i_trim_height (i_trim_height),
        .i_group_id    (i_group_id),
        .o_wr          (front_wr),
        .o_entry       (front_entry)
    );

    slp_queue #(
        .WIDTH (EW),
        .DEPTH (MID_DEPTH)
    ) u_mid_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (front_wr),
        .i_wr_data (front_entry),
        .i_rd      (back_take),
        .o_rd_data (mid_head),
        .o_full    (mid_full),
        .o_empty   (mid_empty)
    );

    slp_back #(
        .COORD_BITS (COORD_BITS),
        .GROUP_BITS (GROUP_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_valid    (!mid_empty),
        .i_entry    (mid_head),
        .o_take     (back_take),
        .i_out_full (out_full),
        .o_wr       (back_wr),
        .o_result   (back_result),
        .o_busy     (back_busy)
    );

    slp_queue #(
        .WIDTH (RW),
        .DEPTH (OUT_DEPTH)
    ) u_out_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (back_wr),
        .i_wr_data (back_result),
        .i_rd      (out_pop),
        .o_rd_data (out_head),
        .o_full    (out_full),
        .o_empty   (empty)
    );

    assign o_pos_x         = out_head[6*C-1 -: C];
    assign o_pos_y         = out_head[5*C-1 -: C];
    assign o_placed_width  = out_head[4*C-1 -: C];
    assign o_placed_height = out_head[3*C-1 -: C];
    assign o_total_width   = out_head[2*C-1 -: C];
    assign o_total_height  = out_head[C-1:0];

    // results queue starts empty after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    // an empty rectangle reports a zero placement
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_placed_width == '0) |->
        (o_pos_x == '0 && o_pos_y == '0 && o_placed_height == '0))
        else $error("zero-width result with nonzero placement");

    // with nothing in flight a pushed word reaches the result queue through the back-end stage
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !full && empty && mid_empty && !back_busy) |=> ##2 !empty)
        else $error("word not delivered within three cycles");

endmodule

// File: verif/shelf_layout_placer_core_tb.sv
`timescale 1ns / 100ps
// self-checking testbench for the shelf layout placer core: queue-style driver, monitor, predictor
module shelf_layout_placer_core_tb;
    import slp_pkg::*;

    localparam int COORD_MAX   = 2**COORD_BITS_DEF - 1;
    localparam int MAX_TRIM    = 2**TRIM_BITS - 1;
    localparam int QUIET_LIMIT = 5000;
    localparam int RAND_PHASES = 12;
    localparam int PHASE_RECTS = 165;

    typedef struct packed {
        logic                      restart;
        logic [TRIM_BITS-1:0]      w;
        logic [TRIM_BITS-1:0]      h;
        logic [GROUP_BITS_DEF-1:0] grp;
    } t_rect;

    typedef struct packed {
        logic [COORD_BITS_DEF-1:0] x;
        logic [COORD_BITS_DEF-1:0] y;
        logic [COORD_BITS_DEF-1:0] w;
        logic [COORD_BITS_DEF-1:0] h;
        logic [COORD_BITS_DEF-1:0] tot_w;
        logic [COORD_BITS_DEF-1:0] tot_h;
    } t_placement;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      psel = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite = 1'b0;
    logic [ADDR_BITS-1:0]      paddr = '0;
    logic [DATA_BITS-1:0]      pwdata = '0;
    logic [DATA_BITS-1:0]      prdata;
    logic                      pready;
    logic                      push = 1'b0;
    logic                      full;
    logic                      i_restart = 1'b0;
    logic [TRIM_BITS-1:0]      i_trim_width = '0;
    logic [TRIM_BITS-1:0]      i_trim_height = '0;
    logic [GROUP_BITS_DEF-1:0] i_group_id = '0;
    logic                      empty;
    logic                      pop = 1'b0;
    logic [COORD_BITS_DEF-1:0] o_pos_x;
    logic [COORD_BITS_DEF-1:0] o_pos_y;
    logic [COORD_BITS_DEF-1:0] o_placed_width;
    logic [COORD_BITS_DEF-1:0] o_placed_height;
    logic [COORD_BITS_DEF-1:0] o_total_width;
    logic [COORD_BITS_DEF-1:0] o_total_height;

    shelf_layout_placer_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .push            (push),
        .full            (full),
        .i_restart       (i_restart),
        .i_trim_width    (i_trim_width),
        .i_trim_height   (i_trim_height),
        .i_group_id      (i_group_id),
        .empty           (empty),
        .pop             (pop),
        .o_pos_x         (o_pos_x),
        .o_pos_y         (o_pos_y),
        .o_placed_width  (o_placed_width),
        .o_placed_height (o_placed_height),
        .o_total_width   (o_total_width),
        .o_total_height  (o_total_height)
    );

    always #5 i_clk = ~i_clk;

    t_rect      pending_rects[$];
    t_placement placements_due[$];

    // predictor copy of configuration and layout state
    t_cfg                      cfg = '0;
    int unsigned               cur_x = 0, cur_y = 0, shelf_w = 0, shelf_h = 0;
    int unsigned               far_right = 0, far_bottom = 0;
    logic [GROUP_BITS_DEF-1:0] last_group = '0;
    bit                        placed_any = 1'b0;

    int mismatches = 0;
    int rects_sent = 0;
    int placements_seen = 0;
    int settings_used = 0;
    int idle_pct = 0;
    int stall_pct = 0;
    int gap_left = 0;
    int stall_left = 0;
    int quiet_cycles = 0;

    function automatic int unsigned clip(input int unsigned v);
        return (v > COORD_MAX) ? COORD_MAX : v;
    endfunction

    function automatic int unsigned wider(input int unsigned a, input int unsigned b);
        return (a > b) ? a : b;
    endfunction

    function automatic int unsigned sheet_extent(input int unsigned lim, input int unsigned ext);
        int unsigned t;
        if (cfg.sheet_width != 0 && cfg.sheet_height != 0)
            t = wider(lim, ext);
        else
            t = placed_any ? ext : lim;
        // no limit on this axis: border is added on top of the extent
        if (lim == 0)
            t += 32'(cfg.border_padding);
        return clip(t);
    endfunction

    function automatic void place_rect(input t_rect r);
        t_placement  p;
        int unsigned grow, bord, pw, ph;
        logic        wrap;
        p = '0;
        bord = 32'(cfg.border_padding);
        if (r.restart) begin
            cur_x = bord;
            cur_y = bord;
            shelf_w = 0;
            shelf_h = 0;
            last_group = '0;
            placed_any = 1'b0;
            far_right = 0;
            far_bottom = 0;
        end
        if (r.w != 0 && r.h != 0) begin
            grow = 2 * cfg.inner_padding + (cfg.extrude ? EXTRUDE_GROW : 0);
            pw = clip(r.w + grow);
            ph = clip(r.h + grow);
            if (!placed_any) begin
                cur_x = bord;
                cur_y = bord;
                shelf_w = 0;
                shelf_h = 0;
            end else begin
                if (cfg.columns_mode)
                    wrap = (cfg.sheet_height == 0) ? (r.grp != last_group)
                                                   : (cur_y + ph + bord > cfg.sheet_height);
                else
                    wrap = (cfg.sheet_width == 0) ? (r.grp != last_group)
                                                  : (cur_x + pw + bord > cfg.sheet_width);
                if (wrap) begin
                    if (cfg.columns_mode) begin
                        cur_x = clip(cur_x + shelf_w + cfg.shape_padding);
                        cur_y = bord;
                    end else begin
                        cur_x = bord;
                        cur_y = clip(cur_y + shelf_h + cfg.shape_padding);
                    end
                    shelf_w = pw;
                    shelf_h = ph;
                end
            end
            p.x = COORD_BITS_DEF'(cur_x);
            p.y = COORD_BITS_DEF'(cur_y);
            p.w = COORD_BITS_DEF'(pw);
            p.h = COORD_BITS_DEF'(ph);
            if (cfg.columns_mode)
                cur_y = clip(cur_y + ph + cfg.shape_padding);
            else
                cur_x = clip(cur_x + pw + cfg.shape_padding);
            shelf_w = wider(shelf_w, pw);
            shelf_h = wider(shelf_h, ph);
            far_right = wider(far_right, clip(p.x + pw + ((cfg.sheet_width != 0) ? bord : 0)));
            far_bottom = wider(far_bottom, clip(p.y + ph + ((cfg.sheet_height != 0) ? bord : 0)));
            last_group = r.grp;
            placed_any = 1'b1;
        end
        p.tot_w = COORD_BITS_DEF'(sheet_extent(cfg.sheet_width, far_right));
        p.tot_h = COORD_BITS_DEF'(sheet_extent(cfg.sheet_height, far_bottom));
        placements_due = {placements_due, p};
    endfunction

    function automatic void add_rect(input logic rs, input int w, input int h,
                                     input logic [GROUP_BITS_DEF-1:0] g);
        t_rect r;
        r.restart = rs;
        r.w = TRIM_BITS'(w);
        r.h = TRIM_BITS'(h);
        r.grp = g;
        pending_rects = {pending_rects, r};
    endfunction

    function automatic t_rect random_rect(input logic [GROUP_BITS_DEF-1:0] g);
        t_rect r;
        r.restart = ($urandom_range(0, 39) == 0);
        r.grp = g;
        r.w = TRIM_BITS'($urandom_range(1, 200));
        r.h = TRIM_BITS'($urandom_range(1, 200));
        case ($urandom_range(0, 15))
            0: r.w = 0;
            1: r.h = 0;
            2: begin
                r.w = TRIM_BITS'($urandom_range(0, MAX_TRIM));
                r.h = TRIM_BITS'($urandom_range(0, MAX_TRIM));
            end
            3: r.w = TRIM_BITS'($urandom_range(1000, MAX_TRIM));
            4: r.h = TRIM_BITS'($urandom_range(1000, MAX_TRIM));
            default: ;
        endcase
        return r;
    endfunction

    function automatic logic [PAD_BITS-1:0] pick_pad();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            default: return PAD_BITS'($urandom_range(0, 16));
        endcase
    endfunction

    function automatic logic [SHEET_BITS-1:0] pick_limit();
        if ($urandom_range(0, 2) == 0)
            return '0;
        case ($urandom_range(0, 3))
            0: return SHEET_BITS'($urandom_range(1, 255));
            1: return '1;
            default: return SHEET_BITS'($urandom_range(256, 4000));
        endcase
    endfunction

    function automatic int pick_rate();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 5;
            2: return 30;
            default: return 70;
        endcase
    endfunction

    function automatic logic [DATA_BITS-1:0] reg_field(input t_cfg c, input t_reg_idx idx);
        case (idx)
            REG_COLUMNS_MODE:   return DATA_BITS'(c.columns_mode);
            REG_BORDER_PADDING: return DATA_BITS'(c.border_padding);
            REG_SHAPE_PADDING:  return DATA_BITS'(c.shape_padding);
            REG_INNER_PADDING:  return DATA_BITS'(c.inner_padding);
            REG_EXTRUDE:        return DATA_BITS'(c.extrude);
            REG_SHEET_WIDTH:    return DATA_BITS'(c.sheet_width);
            REG_SHEET_HEIGHT:   return DATA_BITS'(c.sheet_height);
            default:            return '0;
        endcase
    endfunction

    task automatic reg_access(input logic wr, input t_reg_idx idx,
                              input logic [DATA_BITS-1:0] wdata,
                              output logic [DATA_BITS-1:0] rdata);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= ADDR_BITS'(idx) << 2;
        pwdata <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        rdata = prdata;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_config(input t_cfg c);
        t_reg_idx             idx;
        logic [DATA_BITS-1:0] rd;
        idx = idx.first();
        do begin
            reg_access(1'b1, idx, reg_field(c, idx), rd);
            idx = idx.next();
        end while (idx != idx.first());
        cfg = c;
        do begin
            reg_access(1'b0, idx, '0, rd);
            if (rd !== reg_field(cfg, idx)) begin
                $display("%0t: register %s readback mismatch: expected %0d, actual %0d",
                         $time, idx.name(), reg_field(cfg, idx), rd);
                mismatches++;
            end
            idx = idx.next();
        end while (idx != idx.first());
        settings_used++;
        @(negedge i_clk);
    endtask

    // block is idle once every queued word went in and every placement came back
    task automatic drain();
        do @(negedge i_clk);
        while (pending_rects.size() != 0 || push || placements_due.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [COORD_BITS_DEF-1:0] want,
                               input logic [COORD_BITS_DEF-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : feed_rects
        t_rect nxt;
        if (!i_rst_n) begin
            push <= 1'b0;
            gap_left = 0;
        end else begin
            if (push && !full) begin
                place_rect({i_restart, i_trim_width, i_trim_height, i_group_id});
                rects_sent++;
            end
            // a word held against full stays put
            if (!push || !full) begin
                if (gap_left > 0) begin
                    gap_left--;
                    push <= 1'b0;
                end else if (pending_rects.size() != 0 && $urandom_range(0, 99) < idle_pct) begin
                    gap_left = $urandom_range(0, 18);
                    push <= 1'b0;
                end else if (pending_rects.size() != 0) begin
                    nxt = pending_rects.pop_front();
                    {i_restart, i_trim_width, i_trim_height, i_group_id} <= nxt;
                    push <= 1'b1;
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : collect_placements
        t_placement want;
        if (!i_rst_n) begin
            pop <= 1'b0;
            stall_left = 0;
        end else begin
            if (pop && !empty) begin
                placements_seen++;
                if (placements_due.size() == 0) begin
                    $display("%0t: unexpected placement at (%0d, %0d), expected none",
                             $time, o_pos_x, o_pos_y);
                    mismatches++;
                end else begin
                    want = placements_due.pop_front();
                    check_field("pos_x", want.x, o_pos_x);
                    check_field("pos_y", want.y, o_pos_y);
                    check_field("placed_width", want.w, o_placed_width);
                    check_field("placed_height", want.h, o_placed_height);
                    check_field("total_width", want.tot_w, o_total_width);
                    check_field("total_height", want.tot_h, o_total_height);
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                pop <= 1'b0;
            end else if ($urandom_range(0, 99) < stall_pct) begin
                stall_left = $urandom_range(0, 18);
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        t_cfg                      c;
        t_rect                     r;
        logic [GROUP_BITS_DEF-1:0] g;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: rows, no limits, so a group change opens a new row
        idle_pct = 20;
        stall_pct = 20;
        add_rect(1'b0, 1, 1, 16'h0000);
        add_rect(1'b0, MAX_TRIM, MAX_TRIM, 16'h0000);
        add_rect(1'b0, 0, 7, 16'h0005);
        add_rect(1'b0, 7, 0, 16'h0005);
        add_rect(1'b0, 3, 4, 16'hFFFF);
        repeat (4) add_rect(1'b0, MAX_TRIM, 2, 16'hFFFF);
        add_rect(1'b1, 10, 10, 16'h0001);
        add_rect(1'b1, 0, 0, 16'h0001);
        drain();

        // everything at its maximum: columns, full paddings, largest sheet
        set_config('1);
        add_rect(1'b1, MAX_TRIM, MAX_TRIM, 16'h0003);
        repeat (3) add_rect(1'b0, 100, MAX_TRIM, 16'h0003);
        add_rect(1'b0, 0, 0, 16'h0003);
        add_rect(1'b0, 1, 1, 16'h0004);
        drain();

        // sheet width below the border: every rectangle after the first wraps
        c = '0;
        c.border_padding = PAD_BITS'(200);
        c.shape_padding = PAD_BITS'(3);
        c.sheet_width = SHEET_BITS'(100);
        set_config(c);
        add_rect(1'b1, 5, 5, 16'h0009);
        repeat (3) add_rect(1'b0, 5, 6, 16'h0009);
        add_rect(1'b0, 1, 1, 16'h000A);
        drain();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            c.columns_mode = 1'($urandom_range(0, 1));
            c.border_padding = pick_pad();
            c.shape_padding = pick_pad();
            c.inner_padding = pick_pad();
            c.extrude = 1'($urandom_range(0, 1));
            c.sheet_width = pick_limit();
            c.sheet_height = pick_limit();
            set_config(c);
            idle_pct = (ph == RAND_PHASES - 1) ? 0 : pick_rate();
            stall_pct = (ph == RAND_PHASES - 1) ? 0 : pick_rate();
            g = GROUP_BITS_DEF'($urandom);
            for (int n = 0; n < PHASE_RECTS; n++) begin
                if ($urandom_range(0, 7) == 0)
                    g = GROUP_BITS_DEF'($urandom);
                r = random_rect(g);
                if (n == 0)
                    r.restart = 1'b1;
                pending_rects = {pending_rects, r};
            end
            drain();
        end

        repeat (8) @(negedge i_clk);
        $display("%0d rectangles pushed, %0d placements checked over %0d register settings",
                 rects_sent, placements_seen, settings_used);
        $display("rows and columns, sheet limits on and off, empty rectangles and restarts");
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: shelf_layout_placer_core.f
rtl/slp_pkg.sv
rtl/slp_queue.sv
rtl/slp_front.sv
rtl/slp_back.sv
rtl/shelf_layout_placer_core.sv
verif/shelf_layout_placer_core_tb.sv
